/* sv/bvd_pkg.sv */
// Shared widths, reset values, register indexes and stage types of the vertical delta decoder.
package bvd_pkg;

   localparam int MAX_PLANES_DEF = 8;
   localparam int ADDR_BITS_DEF  = 24;

   localparam int ROW_STRIDE_W   = 13;
   localparam int PLANE_STRIDE_W = 10;
   localparam int COL_W          = 11;
   localparam int ROW_W          = 13;
   localparam int OFFSET_W       = 13;   // plane index times plane stride
   localparam int STEP_W         = 21;   // byte times row stride
   localparam int OUT_ADDR_W     = 24;
   localparam int SUM_W          = 33;   // wide enough for any address add
   localparam int CSR_INDEX_W    = 8;
   localparam int CSR_DATA_W     = 13;

   localparam logic [ROW_W-1:0] ROW_MAX = 13'h1FFF;

   localparam logic [ROW_STRIDE_W-1:0]   ROW_STRIDE_RST   = 13'd320;
   localparam logic [PLANE_STRIDE_W-1:0] PLANE_STRIDE_RST = 10'd40;
   localparam logic [COL_W-1:0]          COLUMN_COUNT_RST = 11'd40;
   localparam logic [ROW_W-1:0]          ROW_LIMIT_RST    = 13'd256;

   localparam logic [CSR_INDEX_W-1:0] REG_ROW_STRIDE   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_STRIDE = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMN_COUNT = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_LIMIT    = 8'd3;

   typedef struct packed {
      logic [ROW_STRIDE_W-1:0]   row_stride;
      logic [PLANE_STRIDE_W-1:0] plane_stride;
      logic [COL_W-1:0]          column_count;
      logic [ROW_W-1:0]          row_limit;
   } cfg_type;

   // item held in the input register, products already formed
   typedef struct packed {
      logic [7:0]        delta;
      logic              plane_begin;
      logic              plane_ok;
      logic [STEP_W-1:0] byte_step;
   } prep_type;

   typedef struct packed {
      logic                  valid;
      logic                  kind;
      logic [OUT_ADDR_W-1:0] address;
      logic [7:0]            data;
      logic [7:0]            run_length;
      logic                  overrun;
   } result_type;

endpackage

/* sv/bvd_prep.sv */
// Input register: holds one item and forms the plane base and byte-times-stride products.
module bvd_prep import bvd_pkg::*; #(
   parameter int MAX_PLANES = MAX_PLANES_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_delta_byte,
   input  logic                  req_plane_begin,
   input  logic [2:0]            req_plane_index,
   input  logic [OUT_ADDR_W-1:0] req_frame_base,
   input  cfg_type               cfg,
   input  logic                  out_can,
   output logic                  advance,
   output prep_type              prep,
   output logic [ADDR_BITS-1:0]  base
);

   logic                 in_vld_ff, in_vld_in;
   prep_type             prep_ff, prep_in;
   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [OFFSET_W-1:0]  offset;
   logic [SUM_W-1:0]     base_sum;
   logic                 accept;

   assign req_stall = in_vld_ff && !out_can;
   assign accept    = req_valid && !req_stall;
   assign advance   = in_vld_ff && out_can;

   always_comb begin
      offset   = OFFSET_W'(req_plane_index) * OFFSET_W'(cfg.plane_stride);
      base_sum = SUM_W'(req_frame_base) + SUM_W'(offset);
      base_in  = base_sum[ADDR_BITS-1:0];
      prep_in.delta       = req_delta_byte;
      prep_in.plane_begin = req_plane_begin;
      prep_in.plane_ok    = int'(req_plane_index) < MAX_PLANES;
      prep_in.byte_step   = STEP_W'(req_delta_byte) * STEP_W'(cfg.row_stride);
      in_vld_in = accept ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (accept) begin
         prep_ff <= prep_in;
         base_ff <= base_in;
      end
   end

   assign prep = prep_ff;
   assign base = base_ff;

endmodule

/* sv/bvd_core.sv */
// Op stream parser: column state, address walk and write command forming.
module bvd_core import bvd_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  prep_type             prep,
   input  logic [ADDR_BITS-1:0] base,
   input  cfg_type              cfg,
   output result_type           result
);

   typedef enum logic [2:0] {
      PH_COUNT, PH_OP, PH_RCOUNT, PH_RVALUE, PH_DUMP, PH_IDLE
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [7:0]           ops_ff, ops_in;
   logic [6:0]           lit_ff, lit_in;
   logic [7:0]           fill_ff, fill_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ADDR_BITS-1:0] cbase_ff, cbase_in;
   logic [ADDR_BITS-1:0] wp_ff, wp_in;

   logic [COL_W-1:0]  cc_even;
   logic              close_col, do_step;
   logic [STEP_W-1:0] step_amt;
   logic [7:0]        row_amt;
   logic [SUM_W-1:0]  wp_sum, cbase_sum;
   logic [ROW_W:0]    row_sum;

   assign cc_even = {cfg.column_count[COL_W-1:1], 1'b0};

   always_comb begin
      phase_in = phase_ff;
      ops_in   = ops_ff;
      lit_in   = lit_ff;
      fill_in  = fill_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      cbase_in = cbase_ff;
      wp_in    = wp_ff;
      result    = '0;
      close_col = 1'b0;
      do_step   = 1'b0;
      step_amt  = '0;
      row_amt   = '0;
      wp_sum    = '0;
      cbase_sum = '0;
      row_sum   = '0;

      // plane start reopens column 0 whatever the phase
      if (prep.plane_begin) begin
         col_in   = '0;
         cbase_in = base;
         wp_in    = base;
         row_in   = '0;
         ops_in   = '0;
         lit_in   = '0;
         fill_in  = '0;
         phase_in = (cc_even != '0 && prep.plane_ok) ? PH_COUNT : PH_IDLE;
      end

      unique case (phase_in)
         PH_COUNT: begin
            ops_in = prep.delta;
            if (prep.delta == 8'd0) close_col = 1'b1;
            else                    phase_in  = PH_OP;
         end
         PH_OP: begin
            ops_in = ops_in - 8'd1;
            if (prep.delta == 8'd0) begin
               phase_in = PH_RCOUNT;
            end else if (prep.delta[7]) begin
               lit_in = prep.delta[6:0];
               if (lit_in != 7'd0)       phase_in  = PH_DUMP;
               else if (ops_in == 8'd0)  close_col = 1'b1;
               else                      phase_in  = PH_OP;
            end else begin
               // skip
               do_step  = 1'b1;
               step_amt = prep.byte_step;
               row_amt  = prep.delta;
               if (ops_in == 8'd0) close_col = 1'b1;
               else                phase_in  = PH_OP;
            end
         end
         PH_RCOUNT: begin
            fill_in  = prep.delta;
            phase_in = PH_RVALUE;
         end
         PH_RVALUE: begin
            if (fill_in != 8'd0) begin
               result.valid      = 1'b1;
               result.kind       = 1'b1;
               result.address    = OUT_ADDR_W'(wp_in);
               result.data       = prep.delta;
               result.run_length = fill_in;
               result.overrun    = (14'(row_in) + 14'(fill_in)) > 14'(cfg.row_limit);
               do_step  = 1'b1;
               // stride taken as it stands when the value byte arrives
               step_amt = STEP_W'(fill_ff) * STEP_W'(cfg.row_stride);
               row_amt  = fill_in;
            end
            fill_in = '0;
            if (ops_in == 8'd0) close_col = 1'b1;
            else                phase_in  = PH_OP;
         end
         PH_DUMP: begin
            result.valid      = 1'b1;
            result.kind       = 1'b0;
            result.address    = OUT_ADDR_W'(wp_in);
            result.data       = prep.delta;
            result.run_length = 8'd1;
            result.overrun    = (14'(row_in) + 14'd1) > 14'(cfg.row_limit);
            do_step  = 1'b1;
            step_amt = STEP_W'(cfg.row_stride);
            row_amt  = 8'd1;
            lit_in   = lit_in - 7'd1;
            if (lit_in == 7'd0) begin
               if (ops_in == 8'd0) close_col = 1'b1;
               else                phase_in  = PH_OP;
            end
         end
         PH_IDLE: begin
         end
         default: begin
         end
      endcase

      if (do_step) begin
         wp_sum  = SUM_W'(wp_in) + SUM_W'(step_amt);
         wp_in   = wp_sum[ADDR_BITS-1:0];
         row_sum = (ROW_W+1)'(row_in) + (ROW_W+1)'(row_amt);
         row_in  = row_sum[ROW_W] ? ROW_MAX : row_sum[ROW_W-1:0];
      end

      // end of column: next column one byte on, row 0
      if (close_col) begin
         col_in    = col_in + 11'd1;
         cbase_sum = SUM_W'(cbase_in) + SUM_W'(1);
         cbase_in  = cbase_sum[ADDR_BITS-1:0];
         wp_in     = cbase_in;
         row_in    = '0;
         ops_in    = '0;
         lit_in    = '0;
         fill_in   = '0;
         phase_in  = (col_in < cc_even) ? PH_COUNT : PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         ops_ff   <= '0;
         lit_ff   <= '0;
         fill_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         cbase_ff <= '0;
         wp_ff    <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         ops_ff   <= ops_in;
         lit_ff   <= lit_in;
         fill_ff  <= fill_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         cbase_ff <= cbase_in;
         wp_ff    <= wp_in;
      end
   end

endmodule

/* sv/bvd_out_stage.sv */
// Result register: holds one write command until the consumer takes it.
module bvd_out_stage import bvd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  result_type            result,
   input  logic                  rsp_stall,
   output logic                  out_can,
   output logic                  rsp_valid,
   output logic                  rsp_write_kind,
   output logic [OUT_ADDR_W-1:0] rsp_write_address,
   output logic [7:0]            rsp_write_data,
   output logic [7:0]            rsp_run_length,
   output logic                  rsp_row_overrun
);

   logic       out_vld_ff, out_vld_in;
   result_type res_ff;
   logic       load;

   assign out_can    = !out_vld_ff || !rsp_stall;
   assign load       = advance && result.valid;
   assign out_vld_in = out_can ? load : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_write_kind    = res_ff.kind;
   assign rsp_write_address = res_ff.address;
   assign rsp_write_data    = res_ff.data;
   assign rsp_run_length    = res_ff.run_length;
   assign rsp_row_overrun   = res_ff.overrun;

endmodule

/* sv/byte_vertical_delta_decoder.sv */
// Top level of the byte vertical delta decoder: register file and stage wiring.
//
// Takes one byte of a bitplane's column-major delta op stream per item and issues
// at most one frame buffer write command per item (single byte or fill run down
// the column). Throughput is one item per clock while req_stall is low: every
// byte passes an input register, where the plane base (frame_base +
// plane_index * plane_stride) and the byte times row_stride product are formed,
// and then one parse stage that updates column state and loads the result
// register. rsp_valid rises when a write command is loaded into the result
// register. req_stall rises only when the input register is full and the result
// register holds an item under rsp_stall. Bytes that give no write (op counts,
// skips, repeat counts) leave no result. Columns end after their counted ops;
// after the last even-rounded column, or for a plane number at or above
// MAX_PLANES, bytes are ignored until the next plane_begin. Addresses wrap at
// ADDR_BITS and show in the 24-bit rsp_write_address. Configuration writes
// (csr_ready always high) must occur only while idle; unknown indexes are
// ignored. No clearing pass follows reset.
module byte_vertical_delta_decoder import bvd_pkg::*; #(
   parameter int MAX_PLANES = MAX_PLANES_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_delta_byte,
   input  logic                   req_plane_begin,
   input  logic [2:0]             req_plane_index,
   input  logic [OUT_ADDR_W-1:0]  req_frame_base,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_write_kind,
   output logic [OUT_ADDR_W-1:0]  rsp_write_address,
   output logic [7:0]             rsp_write_data,
   output logic [7:0]             rsp_run_length,
   output logic                   rsp_row_overrun,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type              cfg_ff, cfg_in;
   logic                 out_can, advance;
   prep_type             prep;
   logic [ADDR_BITS-1:0] base;
   result_type           result;

   assign csr_ready = 1'b1;

   // register file decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ROW_STRIDE:   cfg_in.row_stride   = csr_data[ROW_STRIDE_W-1:0];
            REG_PLANE_STRIDE: cfg_in.plane_stride = csr_data[PLANE_STRIDE_W-1:0];
            REG_COLUMN_COUNT: cfg_in.column_count = csr_data[COL_W-1:0];
            REG_ROW_LIMIT:    cfg_in.row_limit    = csr_data[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_stride   <= ROW_STRIDE_RST;
         cfg_ff.plane_stride <= PLANE_STRIDE_RST;
         cfg_ff.column_count <= COLUMN_COUNT_RST;
         cfg_ff.row_limit    <= ROW_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bvd_prep #(
      .MAX_PLANES (MAX_PLANES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_prep (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_delta_byte  (req_delta_byte),
      .req_plane_begin (req_plane_begin),
      .req_plane_index (req_plane_index),
      .req_frame_base  (req_frame_base),
      .cfg             (cfg_ff),
      .out_can         (out_can),
      .advance         (advance),
      .prep            (prep),
      .base            (base)
   );

   bvd_core #(
      .ADDR_BITS (ADDR_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .prep    (prep),
      .base    (base),
      .cfg     (cfg_ff),
      .result  (result)
   );

   bvd_out_stage u_out (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .result            (result),
      .rsp_stall         (rsp_stall),
      .out_can           (out_can),
      .rsp_valid         (rsp_valid),
      .rsp_write_kind    (rsp_write_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_run_length    (rsp_run_length),
      .rsp_row_overrun   (rsp_row_overrun)
   );

endmodule

/* sv/bvd_checker.sv */
// Port-level checker for the vertical delta decoder, bound to the top level.
module bvd_checker import bvd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [7:0]             req_delta_byte,
   input logic                   req_plane_begin,
   input logic [2:0]             req_plane_index,
   input logic [OUT_ADDR_W-1:0]  req_frame_base,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_write_kind,
   input logic [OUT_ADDR_W-1:0]  rsp_write_address,
   input logic [7:0]             rsp_write_data,
   input logic [7:0]             rsp_run_length,
   input logic                   rsp_row_overrun
);

   // a held write command keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_address)
         && $stable(rsp_write_data) && $stable(rsp_run_length)
         && $stable(rsp_write_kind) && $stable(rsp_row_overrun))
      else $error("stalled write command changed");

   // a stalled request item stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_delta_byte)
         && $stable(req_plane_begin) && $stable(req_plane_index)
         && $stable(req_frame_base))
      else $error("stalled request item changed");

   // single writes cover exactly one row
   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_kind |-> rsp_run_length == 8'd1)
      else $error("single write with run length other than one");

   // fills are never empty
   a_fill_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_kind |-> rsp_run_length != 8'd0)
      else $error("empty fill issued");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output or stall active after reset");

endmodule

bind byte_vertical_delta_decoder bvd_checker u_bvd_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the byte vertical delta decoder: directed and random op streams.
module tb;
   import bvd_pkg::*;

   // ---------------------------------------------------------------------------------------
   // Local codes
   // ---------------------------------------------------------------------------------------
   typedef enum logic [2:0] {
      AWAIT_COUNT, AWAIT_OP, AWAIT_FILL_COUNT, AWAIT_FILL_VALUE, IN_LITERALS, PLANE_DONE
   } parse_phase_type;

   typedef enum int {NO_IDLE, SENDER_IDLE, RECEIVER_STALL, BOTH_IDLE} idle_mode_type;

   typedef struct packed {
      logic                  kind;
      logic [OUT_ADDR_W-1:0] address;
      logic [7:0]            data;
      logic [7:0]            run_length;
      logic                  overrun;
   } write_cmd_type;

   localparam logic       KIND_SINGLE  = 1'b0;
   localparam logic       KIND_FILL    = 1'b1;
   localparam logic [7:0] OP_REPEAT    = 8'h00;   // repeat: count byte, value byte follow
   localparam logic [7:0] OP_DUMP      = 8'h80;   // dump flag, low 7 bits = literal count
   localparam int         DRAIN_CYCLES = 8;       // two-stage pipe plus margin
   localparam int         RANDOM_ITEMS = 1800;

   // ---------------------------------------------------------------------------------------
   // DUT connections
   // ---------------------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_delta_byte;
   logic                   req_plane_begin;
   logic [2:0]             req_plane_index;
   logic [OUT_ADDR_W-1:0]  req_frame_base;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_write_kind;
   logic [OUT_ADDR_W-1:0]  rsp_write_address;
   logic [7:0]             rsp_write_data;
   logic [7:0]             rsp_run_length;
   logic                   rsp_row_overrun;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   byte_vertical_delta_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_delta_byte    (req_delta_byte),
      .req_plane_begin   (req_plane_begin),
      .req_plane_index   (req_plane_index),
      .req_frame_base    (req_frame_base),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_kind    (rsp_write_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_run_length    (rsp_run_length),
      .rsp_row_overrun   (rsp_row_overrun),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Decoder state mirror and register shadows
   // ---------------------------------------------------------------------------------------
   logic [ROW_STRIDE_W-1:0]   stride_row;
   logic [PLANE_STRIDE_W-1:0] stride_plane;
   logic [COL_W-1:0]          columns;
   logic [ROW_W-1:0]          limit_rows;

   parse_phase_type       phase;
   logic [7:0]            ops_left;
   logic [6:0]            literals_left;
   logic [7:0]            fill_len;
   logic [COL_W-1:0]      col_num;
   logic [ROW_W-1:0]      row_num;
   logic [OUT_ADDR_W-1:0] col_base;
   logic [OUT_ADDR_W-1:0] wr_ptr;

   write_cmd_type pending_writes[$];   // expected write commands, oldest first
   int         mismatches = 0;
   int         bytes_sent = 0;
   int         sender_pct = 0;
   int         receiver_pct = 0;
   logic       plane_open_pending = 1'b0;

   function void reset_decoder_mirror();
      stride_row    = ROW_STRIDE_RST;
      stride_plane  = PLANE_STRIDE_RST;
      columns       = COLUMN_COUNT_RST;
      limit_rows    = ROW_LIMIT_RST;
      phase         = AWAIT_COUNT;
      ops_left      = '0;
      literals_left = '0;
      fill_len      = '0;
      col_num       = '0;
      row_num       = '0;
      col_base      = '0;
      wr_ptr        = '0;
   endfunction

   // columns come in word pairs: the low bit of the column count is dropped
   function void open_column();
      wr_ptr        = col_base;
      row_num       = '0;
      ops_left      = '0;
      literals_left = '0;
      fill_len      = '0;
      phase = (col_num < (columns & 11'h7FE)) ? AWAIT_COUNT : PLANE_DONE;
   endfunction

   function void close_column();
      col_num  = col_num + 1'b1;
      col_base = col_base + 1'b1;
      open_column();
   endfunction

   function void finish_op();
      if (ops_left == 0)
         close_column();
      else
         phase = AWAIT_OP;
   endfunction

   // pointer wraps at 24 bits, row count saturates
   function void step_rows(input logic [7:0] n);
      int sum;
      wr_ptr = wr_ptr + OUT_ADDR_W'(n) * OUT_ADDR_W'(stride_row);
      sum = int'(row_num) + int'(n);
      row_num = (sum > int'(ROW_MAX)) ? ROW_MAX : ROW_W'(sum);
   endfunction

   function void push_write(input logic kind, input logic [7:0] data, input logic [7:0] len);
      write_cmd_type w;
      w.kind       = kind;
      w.address    = wr_ptr;
      w.data       = data;
      w.run_length = len;
      w.overrun    = (int'(row_num) + int'(len)) > int'(limit_rows);
      pending_writes.push_back(w);
   endfunction

   // advance the mirror by one accepted delta byte
   function void decode_delta_byte(input logic [7:0] b, input logic first,
                                   input logic [2:0] plane, input logic [OUT_ADDR_W-1:0] base);
      if (first) begin
         col_num  = '0;
         col_base = base + OUT_ADDR_W'(plane) * OUT_ADDR_W'(stride_plane);
         open_column();
         if (int'(plane) >= MAX_PLANES_DEF)
            phase = PLANE_DONE;
      end
      case (phase)
         AWAIT_COUNT: begin
            ops_left = b;
            if (b == 0)
               close_column();
            else
               phase = AWAIT_OP;
         end
         AWAIT_OP: begin
            ops_left = ops_left - 1'b1;
            if (b == OP_REPEAT) begin
               phase = AWAIT_FILL_COUNT;
            end else if ((b & OP_DUMP) != 0) begin
               literals_left = b[6:0];
               if (literals_left == 0)
                  finish_op();
               else
                  phase = IN_LITERALS;
            end else begin
               step_rows(b);
               finish_op();
            end
         end
         AWAIT_FILL_COUNT: begin
            fill_len = b;
            phase    = AWAIT_FILL_VALUE;
         end
         AWAIT_FILL_VALUE: begin
            if (fill_len != 0) begin
               push_write(KIND_FILL, b, fill_len);
               step_rows(fill_len);
            end
            fill_len = '0;
            finish_op();
         end
         IN_LITERALS: begin
            push_write(KIND_SINGLE, b, 8'd1);
            step_rows(8'd1);
            literals_left = literals_left - 1'b1;
            if (literals_left == 0)
               finish_op();
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Receiver: random stall, driven at the falling edge
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_pct);
   end

   // Result check: every accepted write is matched against the oldest expectation.
   always @(posedge clock) begin
      write_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            $error("write with none expected: address %h data %h", rsp_write_address,
                   rsp_write_data);
            mismatches++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_write_kind !== want.kind) begin
               $error("write_kind: expected %0d, got %0d", want.kind, rsp_write_kind);
               mismatches++;
            end
            if (rsp_write_address !== want.address) begin
               $error("write_address: expected %h, got %h", want.address, rsp_write_address);
               mismatches++;
            end
            if (rsp_write_data !== want.data) begin
               $error("write_data: expected %h, got %h", want.data, rsp_write_data);
               mismatches++;
            end
            if (rsp_run_length !== want.run_length) begin
               $error("run_length: expected %0d, got %0d", want.run_length, rsp_run_length);
               mismatches++;
            end
            if (rsp_row_overrun !== want.overrun) begin
               $error("row_overrun: expected %0d, got %0d", want.overrun, rsp_row_overrun);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------------
   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         SENDER_IDLE:    begin sender_pct = 63; receiver_pct = 0;  end
         RECEIVER_STALL: begin sender_pct = 0;  receiver_pct = 63; end
         BOTH_IDLE:      begin sender_pct = 33; receiver_pct = 33; end
         default:        begin sender_pct = 0;  receiver_pct = 0;  end
      endcase
   endtask

   // one item; valid stays high after acceptance until the next falling edge decides
   task automatic send_byte(input logic [7:0] b, input logic first, input logic [2:0] plane,
                            input logic [OUT_ADDR_W-1:0] base);
      @(negedge clock);
      while ($urandom_range(99) < sender_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_delta_byte  <= b;
      req_plane_begin <= first;
      req_plane_index <= plane;
      req_frame_base  <= base;
      do @(posedge clock); while (req_stall);
      decode_delta_byte(b, first, plane, base);
      bytes_sent++;
   endtask

   // stream byte: the first after a plane request carries plane_begin, others random
   // don't-care plane fields
   task automatic send_stream(input logic [7:0] b);
      logic [OUT_ADDR_W-1:0] base;
      if (plane_open_pending) begin
         base = ($urandom_range(3) == 0) ? OUT_ADDR_W'(24'hFFFFFF - $urandom_range(2047))
                                         : OUT_ADDR_W'($urandom);
         plane_open_pending = 1'b0;
         send_byte(b, 1'b1, 3'($urandom), base);
      end else begin
         send_byte(b, 1'b0, 3'($urandom), OUT_ADDR_W'($urandom));
      end
   endtask

   // idle until all writes are in and the pipe has emptied of no-write bytes
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ROW_STRIDE:   stride_row   = value[ROW_STRIDE_W-1:0];
         REG_PLANE_STRIDE: stride_plane = value[PLANE_STRIDE_W-1:0];
         REG_COLUMN_COUNT: columns      = value[COL_W-1:0];
         REG_ROW_LIMIT:    limit_rows   = value[ROW_W-1:0];
         default: ;   // unknown index, ignored
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Random stream pieces
   // ---------------------------------------------------------------------------------------
   task automatic send_op();
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_stream(OP_REPEAT);
         send_stream(($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
         send_stream(8'($urandom));
      end else if (pick < 65) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(6);
         send_stream(OP_DUMP | 8'(len));
         repeat (len) send_stream(8'($urandom));
      end else begin
         send_stream(8'($urandom_range(1, 127)));   // skip
      end
   endtask

   task automatic send_column();
      int nops;
      nops = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
      send_stream(8'(nops));
      repeat (nops) send_op();
   endtask

   // random bytes; some carry plane_begin and break whatever was in progress
   task automatic send_noise(input int n);
      repeat (n)
         send_byte(8'($urandom), ($urandom_range(5) == 0), 3'($urandom),
                   OUT_ADDR_W'($urandom));
   endtask

   task automatic send_plane();
      plane_open_pending = 1'b1;
      repeat ($urandom_range(1, 7)) send_column();
      if ($urandom_range(9) == 0)
         send_noise($urandom_range(1, 6));
   endtask

   task automatic random_settings();
      logic [CSR_DATA_W-1:0] v;
      case ($urandom_range(3))
         0:       v = '0;
         1:       v = 13'd8191;
         default: v = CSR_DATA_W'($urandom_range(8191));
      endcase
      write_register(REG_ROW_STRIDE, v);
      case ($urandom_range(2))
         0:       v = '0;
         1:       v = 13'd1023;
         default: v = CSR_DATA_W'($urandom_range(1023));
      endcase
      write_register(REG_PLANE_STRIDE, v);
      // mostly a few columns so plane ends are reached often
      case ($urandom_range(9))
         0:       v = CSR_DATA_W'($urandom_range(1, 3) * 2 + 1);
         1:       v = ($urandom_range(1) == 0) ? 13'd0 : 13'd1;
         2:       v = ($urandom_range(1) == 0) ? 13'd2047 : CSR_DATA_W'($urandom_range(2047));
         default: v = CSR_DATA_W'($urandom_range(1, 4) * 2);
      endcase
      write_register(REG_COLUMN_COUNT, v);
      case ($urandom_range(4))
         0:       v = '0;
         1:       v = 13'd1;
         2:       v = 13'd8191;
         3:       v = CSR_DATA_W'($urandom_range(1, 4096));
         default: v = CSR_DATA_W'($urandom_range(8, 400));
      endcase
      write_register(REG_ROW_LIMIT, v);
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Every op kind at reset settings: skip, dump, fill reaching past the row limit,
   // empty dump, empty fill, zero-op column, plane base wrapping past the top of
   // memory, and a plane start in the middle of a column.
   task automatic test_basic_ops();
      plane_open_pending = 1'b0;
      send_byte(8'd5, 1'b1, 3'd7, 24'hFFFFF0);
      send_stream(8'd1);
      send_stream(OP_DUMP | 8'd2);
      send_stream(8'h00);
      send_stream(8'hFF);
      send_stream(OP_REPEAT);
      send_stream(8'd255);
      send_stream(8'hAA);
      send_stream(OP_DUMP);
      send_stream(OP_REPEAT);
      send_stream(8'd0);
      send_stream(8'h55);
      send_stream(8'd0);                 // column with no ops
      send_stream(8'd1);
      send_stream(8'h7F);                // largest skip
      send_stream(8'd2);
      send_stream(OP_DUMP | 8'd1);
      send_stream(8'h3C);
      send_stream(OP_REPEAT);
      send_stream(8'd1);
      send_byte(8'd2, 1'b1, 3'd0, 24'h000000);   // new plane mid-fill
      send_stream(OP_DUMP | 8'd1);
      send_stream(8'h01);
      send_stream(OP_DUMP | 8'h7F);
      send_stream(8'hC3);
      drain();
   endtask

   task automatic send_small_plane(input logic [2:0] plane, input logic [OUT_ADDR_W-1:0] base);
      send_byte(8'd2, 1'b1, plane, base);
      send_stream(OP_DUMP | 8'd1);
      send_stream(8'($urandom));
      send_stream(OP_REPEAT);
      send_stream(8'd3);
      send_stream(8'($urandom));
   endtask

   // Register extremes, unknown register indexes, and wrap of every address term.
   task automatic test_register_extremes();
      write_register(REG_ROW_STRIDE, 13'h1FFF);
      write_register(REG_PLANE_STRIDE, 13'h1FFF);
      write_register(REG_COLUMN_COUNT, 13'h1FFF);
      write_register(REG_ROW_LIMIT, 13'd0);          // flags every write
      write_register(8'hFF, 13'h0000);
      write_register(8'd4, 13'h1FFF);
      send_small_plane(3'd7, 24'hFFFFFF);
      drain();
      write_register(REG_ROW_STRIDE, 13'd0);
      write_register(REG_PLANE_STRIDE, 13'd0);
      write_register(REG_ROW_LIMIT, 13'h1FFF);
      send_small_plane(3'd5, 24'h123456);
      drain();
   endtask

   // Odd column count rounds down; counts of 0 and 1 leave every plane idle.
   task automatic test_column_limits();
      write_register(REG_ROW_STRIDE, 13'd40);
      write_register(REG_ROW_LIMIT, 13'd2);
      write_register(REG_COLUMN_COUNT, 13'd3);
      send_byte(8'd1, 1'b1, 3'd1, 24'h001000);
      send_stream(OP_DUMP | 8'd1);
      send_stream(8'h11);
      send_stream(8'd1);
      send_stream(OP_DUMP | 8'd1);
      send_stream(8'h22);
      send_stream(8'd1);                 // third column: past the end, ignored
      send_stream(OP_DUMP | 8'd1);
      send_stream(8'h33);
      drain();
      write_register(REG_COLUMN_COUNT, 13'd0);
      send_small_plane(3'd2, 24'h002000);
      drain();
      write_register(REG_COLUMN_COUNT, 13'd1);
      send_small_plane(3'd3, 24'h003000);
      drain();
   endtask

   // Enough skips in one column to pin the row count at its ceiling, then writes.
   task automatic test_row_saturation();
      write_register(REG_COLUMN_COUNT, 13'd40);
      write_register(REG_ROW_LIMIT, 13'd8191);
      write_register(REG_ROW_STRIDE, CSR_DATA_W'($urandom_range(8191)));
      plane_open_pending = 1'b1;
      send_stream(8'd68);
      repeat (66) send_stream(8'd127);
      send_stream(OP_DUMP | 8'd1);
      send_stream(8'h5A);
      send_stream(OP_REPEAT);
      send_stream(8'd255);
      send_stream(8'hA5);
      drain();
   endtask

   // Mostly well-formed planes with random content, some noise; settings and idling
   // change between phases.
   task automatic test_random_stream();
      int start;
      start = bytes_sent;
      for (int p = 0; p < 8; p++) begin
         drain();
         random_settings();
         set_idling(idle_mode_type'(p % 4));
         while (bytes_sent - start < (p + 1) * RANDOM_ITEMS / 8) begin
            if ($urandom_range(9) == 0)
               send_noise($urandom_range(1, 8));
            else
               send_plane();
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_delta_byte  = '0;
      req_plane_begin = 1'b0;
      req_plane_index = '0;
      req_frame_base  = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      set_idling(NO_IDLE);
      reset_decoder_mirror();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      set_idling(BOTH_IDLE);
      test_register_extremes();
      test_column_limits();
      set_idling(NO_IDLE);
      test_row_saturation();
      test_random_stream();
      drain();

      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule
